>>> rtl/core/sats_pkg.sv
// ----------------------------------------------------------------------------
// sats_pkg
// Shared types and constants for the sorted activity table selector.
// ----------------------------------------------------------------------------
package sats_pkg;

    localparam int DEF_ENTRIES   = 16;
    localparam int DEF_TIME_BITS = 16;

    localparam int PORT_TIME_BITS = 16;
    localparam int POS_BITS       = 5;

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_DELETE = 2'd1,
        OP_SELECT = 2'd2
    } opcode_t;

    typedef enum logic [1:0] {
        STS_OK     = 2'd0,
        STS_FULL   = 2'd1,
        STS_NO_POS = 2'd2,
        STS_EMPTY  = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_SWEEP,
        ST_FLUSH
    } state_t;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_INSERT,
        CELL_ROTATE,
        CELL_DROP
    } cell_cmd_t;

endpackage

>>> rtl/core/sats_cell.sv
// ----------------------------------------------------------------------------
// sats_cell
// One table slot: holds a start/finish pair and moves it along the chain.
// ----------------------------------------------------------------------------
module sats_cell
    import sats_pkg::*;
#(
    parameter int INDEX     = 0,
    parameter int TIME_BITS = DEF_TIME_BITS,
    parameter int CNT_BITS  = 5
)
(
    input  logic                 clk,
    input  cell_cmd_t            cmd,
    input  logic [CNT_BITS-1:0]  count,
    input  logic [TIME_BITS-1:0] new_start,
    input  logic [TIME_BITS-1:0] new_finish,
    input  logic [TIME_BITS-1:0] left_start,
    input  logic [TIME_BITS-1:0] left_finish,
    input  logic                 left_take,
    input  logic [TIME_BITS-1:0] right_start,
    input  logic [TIME_BITS-1:0] right_finish,
    input  logic [TIME_BITS-1:0] head_start,
    input  logic [TIME_BITS-1:0] head_finish,
    output logic [TIME_BITS-1:0] start_value,
    output logic [TIME_BITS-1:0] finish_value,
    output logic                 take
);

    localparam logic [CNT_BITS-1:0] MY_IDX  = CNT_BITS'(INDEX);
    localparam logic [CNT_BITS-1:0] NEXT_IDX = CNT_BITS'(INDEX + 1);

    logic [TIME_BITS-1:0] start_reg, start_next;
    logic [TIME_BITS-1:0] finish_reg, finish_next;
    logic                 occupied;
    logic                 has_right;
    logic                 is_tail;

    assign occupied  = MY_IDX < count;
    assign has_right = NEXT_IDX < count;
    assign is_tail   = NEXT_IDX == count;

    // head slot yields only to a strictly earlier finish; others to any not-later one
    always_comb
    begin
        if (INDEX == 0)
        begin
            take = !occupied || (new_finish < finish_reg);
        end
        else
        begin
            take = !occupied || (finish_reg >= new_finish);
        end
    end

    always_comb
    begin
        start_next  = start_reg;
        finish_next = finish_reg;
        case (cmd)
            CELL_INSERT:
            begin
                if (left_take)
                begin
                    start_next  = left_start;
                    finish_next = left_finish;
                end
                else if (take)
                begin
                    start_next  = new_start;
                    finish_next = new_finish;
                end
            end
            CELL_ROTATE:
            begin
                if (has_right)
                begin
                    start_next  = right_start;
                    finish_next = right_finish;
                end
                else if (is_tail)
                begin
                    start_next  = head_start;
                    finish_next = head_finish;
                end
            end
            CELL_DROP:
            begin
                if (has_right)
                begin
                    start_next  = right_start;
                    finish_next = right_finish;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        start_reg  <= start_next;
        finish_reg <= finish_next;
    end

    assign start_value  = start_reg;
    assign finish_value = finish_reg;

endmodule

>>> rtl/core/sorted_activity_table_selector.sv
// ----------------------------------------------------------------------------
// sorted_activity_table_selector
// Finish-ordered activity table with insert, delete and greedy selection.
// ----------------------------------------------------------------------------
// The table is a row of ENTRIES cells, one activity each. An item is taken
// into a command register when the block is idle, so a new word is accepted
// while the previous result still waits on the output. Insert and all error
// cases finish after the capture and the execute state, which for an insert
// does one parallel shift of the row. Delete and select rotate the row past the
// head cell, one entry per cycle, emitting up to one result word per cycle;
// a select ends with a flush of its last word. Output stalls pause the rotation.
// ----------------------------------------------------------------------------
module sorted_activity_table_selector
    import sats_pkg::*;
#(
    parameter int ENTRIES   = DEF_ENTRIES,
    parameter int TIME_BITS = DEF_TIME_BITS
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      item_valid,
    output logic                      item_ready,
    input  logic [1:0]                opcode,
    input  logic [PORT_TIME_BITS-1:0] start_time,
    input  logic [PORT_TIME_BITS-1:0] finish_time,
    input  logic [POS_BITS-1:0]       position,
    output logic                      result_valid,
    input  logic                      result_ready,
    output logic [1:0]                status,
    output logic [POS_BITS-1:0]       entry_position,
    output logic [PORT_TIME_BITS-1:0] entry_start,
    output logic [PORT_TIME_BITS-1:0] entry_finish,
    output logic                      last
);

    localparam int CNT_BITS = $clog2(ENTRIES + 1);
    localparam int IDX_BITS = $clog2(ENTRIES);
    localparam int CMP_BITS = (CNT_BITS > POS_BITS) ? CNT_BITS : POS_BITS;

    state_t                state_reg, state_next;
    opcode_t               op_reg, op_next;
    logic [TIME_BITS-1:0]  cmd_start_reg, cmd_start_next;
    logic [TIME_BITS-1:0]  cmd_finish_reg, cmd_finish_next;
    logic [POS_BITS-1:0]   cmd_pos_reg, cmd_pos_next;
    logic [CNT_BITS-1:0]   count_reg, count_next;
    logic [CNT_BITS-1:0]   len_reg, len_next;
    logic [IDX_BITS-1:0]   idx_reg, idx_next;
    logic [TIME_BITS-1:0]  last_fin_reg, last_fin_next;
    logic [IDX_BITS-1:0]   pend_idx_reg, pend_idx_next;
    logic [TIME_BITS-1:0]  pend_start_reg, pend_start_next;
    logic [TIME_BITS-1:0]  pend_finish_reg, pend_finish_next;

    logic                  out_valid_reg, out_valid_next;
    status_t               out_status_reg, out_status_next;
    logic [POS_BITS-1:0]   out_pos_reg, out_pos_next;
    logic [TIME_BITS-1:0]  out_start_reg, out_start_next;
    logic [TIME_BITS-1:0]  out_finish_reg, out_finish_next;
    logic                  out_last_reg, out_last_next;

    logic                  emit;
    status_t               em_status;
    logic [POS_BITS-1:0]   em_pos;
    logic [TIME_BITS-1:0]  em_start;
    logic [TIME_BITS-1:0]  em_finish;
    logic                  em_last;

    cell_cmd_t             cell_cmd;
    logic [TIME_BITS-1:0]  cell_start [ENTRIES];
    logic [TIME_BITS-1:0]  cell_finish [ENTRIES];
    logic                  cell_take [ENTRIES];
    logic                  cell_spot [ENTRIES];
    logic [CNT_BITS-1:0]   ins_pos;

    logic                  item_accept;
    logic                  slot_free;
    logic                  table_full;
    logic                  pos_ok;
    logic [CNT_BITS-1:0]   idx_p1;
    logic                  sweep_end;
    logic                  del_hit;
    logic                  choose;

    assign item_accept = item_valid && item_ready;
    assign item_ready  = state_reg == ST_IDLE;
    assign slot_free   = !out_valid_reg || result_ready;
    assign table_full  = count_reg == CNT_BITS'(ENTRIES);
    assign pos_ok      = (cmd_pos_reg != '0)
                         && (CMP_BITS'(cmd_pos_reg) <= CMP_BITS'(count_reg));
    assign idx_p1      = CNT_BITS'(idx_reg) + CNT_BITS'(1);
    assign sweep_end   = idx_p1 == len_reg;
    assign del_hit     = CMP_BITS'(idx_p1) == CMP_BITS'(cmd_pos_reg);
    assign choose      = (idx_reg == '0) || (last_fin_reg <= cell_start[0]);

    // cell row
    genvar g;
    generate
        for (g = 0; g < ENTRIES; g++)
        begin : g_cell
            logic [TIME_BITS-1:0] l_start, l_finish, r_start, r_finish;
            logic                 l_take;

            if (g == 0)
            begin : g_first
                assign l_start  = '0;
                assign l_finish = '0;
                assign l_take   = 1'b0;
            end
            else
            begin : g_mid
                assign l_start  = cell_start[g-1];
                assign l_finish = cell_finish[g-1];
                assign l_take   = cell_take[g-1];
            end

            if (g == ENTRIES - 1)
            begin : g_end
                assign r_start  = '0;
                assign r_finish = '0;
            end
            else
            begin : g_inner
                assign r_start  = cell_start[g+1];
                assign r_finish = cell_finish[g+1];
            end

            assign cell_spot[g] = cell_take[g] && !l_take;

            sats_cell #(
                .INDEX     (g),
                .TIME_BITS (TIME_BITS),
                .CNT_BITS  (CNT_BITS)
            ) u_cell (
                .clk          (clk),
                .cmd          (cell_cmd),
                .count        (count_reg),
                .new_start    (cmd_start_reg),
                .new_finish   (cmd_finish_reg),
                .left_start   (l_start),
                .left_finish  (l_finish),
                .left_take    (l_take),
                .right_start  (r_start),
                .right_finish (r_finish),
                .head_start   (cell_start[0]),
                .head_finish  (cell_finish[0]),
                .start_value  (cell_start[g]),
                .finish_value (cell_finish[g]),
                .take         (cell_take[g])
            );
        end
    endgenerate

    // insert point is one-hot along the row
    always_comb
    begin
        ins_pos = '0;
        for (int i = 0; i < ENTRIES; i++)
        begin
            if (cell_spot[i])
            begin
                ins_pos = ins_pos | CNT_BITS'(i + 1);
            end
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (item_accept)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                case (op_reg)
                    OP_INSERT:
                    begin
                        if (slot_free)
                        begin
                            state_next = ST_IDLE;
                        end
                    end
                    OP_DELETE:
                    begin
                        if (slot_free)
                        begin
                            state_next = pos_ok ? ST_SWEEP : ST_IDLE;
                        end
                    end
                    OP_SELECT:
                    begin
                        if (slot_free)
                        begin
                            state_next = (count_reg == '0) ? ST_IDLE : ST_SWEEP;
                        end
                    end
                    default:
                    begin
                        state_next = ST_IDLE;
                    end
                endcase
            end
            ST_SWEEP:
            begin
                if (slot_free && sweep_end)
                begin
                    state_next = (op_reg == OP_SELECT) ? ST_FLUSH : ST_IDLE;
                end
            end
            ST_FLUSH:
            begin
                if (slot_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        op_next          = op_reg;
        cmd_start_next   = cmd_start_reg;
        cmd_finish_next  = cmd_finish_reg;
        cmd_pos_next     = cmd_pos_reg;
        count_next       = count_reg;
        len_next         = len_reg;
        idx_next         = idx_reg;
        last_fin_next    = last_fin_reg;
        pend_idx_next    = pend_idx_reg;
        pend_start_next  = pend_start_reg;
        pend_finish_next = pend_finish_reg;
        cell_cmd         = CELL_HOLD;
        emit             = 1'b0;
        em_status        = STS_OK;
        em_pos           = '0;
        em_start         = '0;
        em_finish        = '0;
        em_last          = 1'b1;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (item_accept)
                begin
                    op_next         = opcode_t'(opcode);
                    cmd_start_next  = TIME_BITS'(start_time);
                    cmd_finish_next = TIME_BITS'(finish_time);
                    cmd_pos_next    = position;
                end
            end
            ST_EXEC:
            begin
                if (slot_free)
                begin
                    idx_next = '0;
                    len_next = count_reg;
                    case (op_reg)
                        OP_INSERT:
                        begin
                            emit = 1'b1;
                            if (table_full)
                            begin
                                em_status = STS_FULL;
                            end
                            else
                            begin
                                em_pos     = POS_BITS'(ins_pos);
                                em_start   = cmd_start_reg;
                                em_finish  = cmd_finish_reg;
                                cell_cmd   = CELL_INSERT;
                                count_next = count_reg + CNT_BITS'(1);
                            end
                        end
                        OP_DELETE:
                        begin
                            if (!pos_ok)
                            begin
                                emit      = 1'b1;
                                em_status = STS_NO_POS;
                            end
                        end
                        OP_SELECT:
                        begin
                            if (count_reg == '0)
                            begin
                                emit      = 1'b1;
                                em_status = STS_EMPTY;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_SWEEP:
            begin
                if (slot_free)
                begin
                    idx_next = IDX_BITS'(idx_p1);
                    if (op_reg == OP_SELECT)
                    begin
                        cell_cmd = CELL_ROTATE;
                        if (choose)
                        begin
                            if (idx_reg != '0)
                            begin
                                emit      = 1'b1;
                                em_pos    = POS_BITS'(CNT_BITS'(pend_idx_reg)
                                                      + CNT_BITS'(1));
                                em_start  = pend_start_reg;
                                em_finish = pend_finish_reg;
                                em_last   = 1'b0;
                            end
                            pend_idx_next    = idx_reg;
                            pend_start_next  = cell_start[0];
                            pend_finish_next = cell_finish[0];
                            last_fin_next    = cell_finish[0];
                        end
                    end
                    else if (del_hit)
                    begin
                        cell_cmd   = CELL_DROP;
                        count_next = count_reg - CNT_BITS'(1);
                        emit       = 1'b1;
                        em_pos     = cmd_pos_reg;
                        em_start   = cell_start[0];
                        em_finish  = cell_finish[0];
                    end
                    else
                    begin
                        cell_cmd = CELL_ROTATE;
                    end
                end
            end
            ST_FLUSH:
            begin
                if (slot_free)
                begin
                    emit      = 1'b1;
                    em_pos    = POS_BITS'(CNT_BITS'(pend_idx_reg) + CNT_BITS'(1));
                    em_start  = pend_start_reg;
                    em_finish = pend_finish_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    // output word register
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_status_next = out_status_reg;
        out_pos_next    = out_pos_reg;
        out_start_next  = out_start_reg;
        out_finish_next = out_finish_reg;
        out_last_next   = out_last_reg;
        if (emit)
        begin
            out_valid_next  = 1'b1;
            out_status_next = em_status;
            out_pos_next    = em_pos;
            out_start_next  = em_start;
            out_finish_next = em_finish;
            out_last_next   = em_last;
        end
        else if (result_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            len_reg       <= '0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            len_reg       <= len_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg          <= op_next;
        cmd_start_reg   <= cmd_start_next;
        cmd_finish_reg  <= cmd_finish_next;
        cmd_pos_reg     <= cmd_pos_next;
        last_fin_reg    <= last_fin_next;
        pend_idx_reg    <= pend_idx_next;
        pend_start_reg  <= pend_start_next;
        pend_finish_reg <= pend_finish_next;
        out_status_reg  <= out_status_next;
        out_pos_reg     <= out_pos_next;
        out_start_reg   <= out_start_next;
        out_finish_reg  <= out_finish_next;
        out_last_reg    <= out_last_next;
    end

    assign result_valid   = out_valid_reg;
    assign status         = out_status_reg;
    assign entry_position = out_pos_reg;
    assign entry_start    = PORT_TIME_BITS'(out_start_reg);
    assign entry_finish   = PORT_TIME_BITS'(out_finish_reg);
    assign last           = out_last_reg;

endmodule

>>> tb/sv/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the sorted activity table selector. A shadow copy
// of the finish-ordered table predicts every result word of each accepted
// command; the words are checked field by field, in order, as they leave the
// block. Directed corner cases come first, then output back-pressure, then
// random traffic with random gaps switched per chunk on both handshakes.
// ----------------------------------------------------------------------------
module testbench;

    import sats_pkg::*;

    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam int         TABLE_MAX = DEF_ENTRIES;
    localparam int         SHOWN_MAX = 10;

    typedef struct packed {
        status_t     sts;
        logic [4:0]  pos;
        logic [15:0] st;
        logic [15:0] fi;
        logic        is_last;
    } table_word_t;

    logic        clk            = 1'b0;
    logic        rst_n          = 1'b0;
    logic        item_valid     = 1'b0;
    logic        item_ready;
    logic [1:0]  opcode         = OP_INSERT;
    logic [15:0] start_time     = '0;
    logic [15:0] finish_time    = '0;
    logic [4:0]  position       = '0;
    logic        result_valid;
    logic        result_ready   = 1'b0;
    logic [1:0]  status;
    logic [4:0]  entry_position;
    logic [15:0] entry_start;
    logic [15:0] entry_finish;
    logic        last;

    // shadow table, kept in finish order
    logic [15:0] act_start [TABLE_MAX];
    logic [15:0] act_finish[TABLE_MAX];
    int          act_count      = 0;

    table_word_t awaited_words[$];
    int          mismatch_count = 0;
    bit          src_gaps_on    = 1'b1;
    bit          sink_stalls_on = 1'b1;
    int          hold_request   = 0;

    sorted_activity_table_selector DUT (
        .clk            (clk),
        .rst_n          (rst_n),
        .item_valid     (item_valid),
        .item_ready     (item_ready),
        .opcode         (opcode),
        .start_time     (start_time),
        .finish_time    (finish_time),
        .position       (position),
        .result_valid   (result_valid),
        .result_ready   (result_ready),
        .status         (status),
        .entry_position (entry_position),
        .entry_start    (entry_start),
        .entry_finish   (entry_finish),
        .last           (last)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic void queue_word(status_t sts, logic [4:0] pos, logic [15:0] st,
                                       logic [15:0] fi, logic fin);
        table_word_t w;
        w.sts     = sts;
        w.pos     = pos;
        w.st      = st;
        w.fi      = fi;
        w.is_last = fin;
        awaited_words.push_back(w);
    endfunction

    function automatic void predict_table_op(logic [1:0] op, logic [15:0] st,
                                             logic [15:0] fi, logic [4:0] pos);
        int          p;
        int          chosen;
        int          picked[$];
        logic [15:0] old_st;
        logic [15:0] old_fi;
        case (op)
            OP_INSERT:
            begin
                if (act_count >= TABLE_MAX)
                    queue_word(STS_FULL, '0, '0, '0, 1'b1);
                else
                begin
                    // equal head finish lands behind the head
                    if (act_count == 0 || fi < act_finish[0])
                        p = 0;
                    else
                    begin
                        p = 1;
                        while (p < act_count && act_finish[p] < fi)
                            p++;
                    end
                    for (int i = act_count; i > p; i--)
                    begin
                        act_start[i]  = act_start[i-1];
                        act_finish[i] = act_finish[i-1];
                    end
                    act_start[p]  = st;
                    act_finish[p] = fi;
                    act_count++;
                    queue_word(STS_OK, 5'(p + 1), st, fi, 1'b1);
                end
            end
            OP_DELETE:
            begin
                if (pos == 0 || pos > act_count)
                    queue_word(STS_NO_POS, '0, '0, '0, 1'b1);
                else
                begin
                    p      = pos - 1;
                    old_st = act_start[p];
                    old_fi = act_finish[p];
                    for (int i = p; i + 1 < act_count; i++)
                    begin
                        act_start[i]  = act_start[i+1];
                        act_finish[i] = act_finish[i+1];
                    end
                    act_count--;
                    queue_word(STS_OK, pos, old_st, old_fi, 1'b1);
                end
            end
            OP_SELECT:
            begin
                if (act_count == 0)
                    queue_word(STS_EMPTY, '0, '0, '0, 1'b1);
                else
                begin
                    chosen = 0;
                    picked.push_back(0);
                    for (int i = 1; i < act_count; i++)
                        if (act_finish[chosen] <= act_start[i])
                        begin
                            chosen = i;
                            picked.push_back(i);
                        end
                    foreach (picked[k])
                        queue_word(STS_OK, 5'(picked[k] + 1), act_start[picked[k]],
                                   act_finish[picked[k]], k == picked.size() - 1);
                end
            end
            default: ;
        endcase
    endfunction

    function automatic void pick_times(output logic [15:0] st, output logic [15:0] fi);
        int k;
        k = $urandom_range(0, 9);
        if (k < 7)
        begin
            st = 16'($urandom_range(0, 120));
            fi = st + 16'($urandom_range(0, 20));
        end
        else if (k < 9)
        begin
            st = 16'($urandom_range(0, 65535));
            fi = 16'($urandom_range(0, 65535));
        end
        else
        begin
            st = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
            fi = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
        end
    endfunction

    task automatic send_word(logic [1:0] op, logic [15:0] st, logic [15:0] fi,
                             logic [4:0] pos);
        int gap;
        item_valid  <= 1'b1;
        opcode      <= op;
        start_time  <= st;
        finish_time <= fi;
        position    <= pos;
        do
            @(posedge clk);
        while (item_ready !== 1'b1);
        predict_table_op(op, st, fi, pos);
        gap = src_gaps_on ? pick_gap() : 0;
        if (gap > 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic wait_drained();
        item_valid <= 1'b0;
        while (awaited_words.size() != 0)
            @(posedge clk);
    endtask

    // returns 0 for a word the block ignores
    task automatic send_random_word(output bit counted);
        int          r;
        logic [15:0] st;
        logic [15:0] fi;
        logic [4:0]  pos;
        counted = 1'b1;
        pick_times(st, fi);
        r = $urandom_range(0, 99);
        if (r < 45 && !(act_count == TABLE_MAX && $urandom_range(0, 2) != 0))
            send_word(OP_INSERT, st, fi, 5'($urandom_range(0, 31)));
        else if (r < 72 && act_count > 0)
            send_word(OP_DELETE, st, fi, 5'($urandom_range(1, act_count)));
        else if (r < 90)
            send_word(OP_SELECT, st, fi, 5'($urandom_range(0, 31)));
        else if (r < 97)
        begin
            pos = $urandom_range(0, 1) ? 5'd0 : 5'($urandom_range(act_count + 1, 31));
            send_word(OP_DELETE, st, fi, pos);
        end
        else
        begin
            counted = 1'b0;
            send_word(OP_UNUSED, 16'($urandom_range(0, 65535)),
                      16'($urandom_range(0, 65535)), 5'($urandom_range(0, 31)));
        end
    endtask

    task automatic test_empty_table();
        send_word(OP_SELECT, 16'd0, 16'd0, 5'd0);
        send_word(OP_DELETE, 16'd0, 16'd0, 5'd1);
        send_word(OP_UNUSED, 16'hFFFF, 16'hFFFF, 5'd31);
    endtask

    task automatic test_ordering_and_capacity();
        logic [15:0] st;
        logic [15:0] fi;
        send_word(OP_INSERT, 16'd100, 16'd200, 5'd0);
        send_word(OP_INSERT, 16'd0, 16'hFFFF, 5'd0);
        send_word(OP_INSERT, 16'd50, 16'd200, 5'd0);
        send_word(OP_INSERT, 16'hFFFF, 16'd0, 5'd0);
        send_word(OP_SELECT, 16'd0, 16'd0, 5'd0);
        while (act_count < TABLE_MAX)
        begin
            pick_times(st, fi);
            send_word(OP_INSERT, st, fi, 5'd0);
        end
        send_word(OP_INSERT, 16'd1, 16'd2, 5'd0);
        send_word(OP_SELECT, 16'd0, 16'd0, 5'd0);
        send_word(OP_DELETE, 16'd0, 16'd0, 5'd1);
        send_word(OP_DELETE, 16'd0, 16'd0, 5'(act_count));
        send_word(OP_DELETE, 16'd0, 16'd0, 5'd31);
        send_word(OP_DELETE, 16'd0, 16'd0, 5'd0);
        wait_drained();
    endtask

    task automatic test_output_backpressure();
        logic [15:0] st;
        logic [15:0] fi;
        wait_drained();
        hold_request = 300;
        src_gaps_on  = 1'b0;
        for (int i = 0; i < 30; i++)
        begin
            pick_times(st, fi);
            if (i % 4 == 3)
                send_word(OP_SELECT, st, fi, 5'd0);
            else if (act_count == TABLE_MAX)
                send_word(OP_DELETE, st, fi, 5'($urandom_range(1, act_count)));
            else
                send_word(OP_INSERT, st, fi, 5'd0);
        end
        src_gaps_on = 1'b1;
        wait_drained();
    endtask

    task automatic test_random_traffic();
        bit counted;
        for (int chunk = 0; chunk < 6; chunk++)
        begin
            src_gaps_on    = (chunk % 2 == 0);
            sink_stalls_on = (chunk % 3 != 1);
            for (int n = 0; n < 45; )
            begin
                send_random_word(counted);
                if (counted)
                    n++;
            end
            if (chunk == 2)
                wait_drained();
        end
        src_gaps_on    = 1'b1;
        sink_stalls_on = 1'b1;
    endtask

    initial
    begin : result_sink
        int stall_left;
        stall_left = 0;
        forever
        begin
            @(posedge clk);
            if (hold_request > 0)
            begin
                stall_left   = hold_request;
                hold_request = 0;
            end
            if (stall_left > 0)
            begin
                result_ready <= 1'b0;
                stall_left--;
            end
            else if (sink_stalls_on && $urandom_range(0, 2) == 0)
            begin
                result_ready <= 1'b0;
                stall_left = pick_gap();
            end
            else
                result_ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin : result_check
        table_word_t want;
        if (rst_n && result_valid && result_ready)
        begin
            if (awaited_words.size() == 0)
            begin
                if (mismatch_count < SHOWN_MAX)
                    $display("unexpected word: sts=%0d pos=%0d st=%0d fi=%0d last=%0d",
                             status, entry_position, entry_start, entry_finish, last);
                mismatch_count++;
            end
            else
            begin
                want = awaited_words.pop_front();
                if (status !== want.sts || entry_position !== want.pos ||
                    entry_start !== want.st || entry_finish !== want.fi ||
                    last !== want.is_last)
                begin
                    if (mismatch_count < SHOWN_MAX)
                    begin
                        $write("mismatch: expected sts=%0d pos=%0d st=%0d fi=%0d last=%0d",
                               want.sts, want.pos, want.st, want.fi, want.is_last);
                        $display(", got sts=%0d pos=%0d st=%0d fi=%0d last=%0d",
                                 status, entry_position, entry_start, entry_finish, last);
                    end
                    mismatch_count++;
                end
            end
        end
    end

    initial
    begin
        #3_000_000;
        $display("sorted_activity_table_selector test failed");
        $finish;
    end

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        test_empty_table();
        test_ordering_and_capacity();
        test_output_backpressure();
        test_random_traffic();
        wait_drained();
        repeat (40) @(posedge clk);
        if (mismatch_count == 0 && awaited_words.size() == 0)
            $display("sorted_activity_table_selector test passed");
        else
            $display("sorted_activity_table_selector test failed");
        $finish;
    end

endmodule
